/* hdl/b64d_pkg.sv */
// Shared types, constants and helper functions for the base64 decoder.
package b64d_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int OUT_COUNT_W = 24;
    localparam int SYM_W       = 7;
    localparam int GROUP_LEN   = 4;
    localparam int MAX_BYTES   = 3;

    localparam logic [SYM_W-1:0] PAD_MARK = 7'h7F;
    localparam logic [7:0]       BAD_MARK = 8'hFF;
    localparam logic [7:0]       CH_PAD   = 8'h3D;
    localparam logic [7:0]       CH_PLUS  = 8'h2B;
    localparam logic [7:0]       CH_SLASH = 8'h2F;
    localparam logic [7:0]       CH_0     = 8'h30;
    localparam logic [7:0]       CH_9     = 8'h39;
    localparam logic [7:0]       CH_UA    = 8'h41;
    localparam logic [7:0]       CH_UZ    = 8'h5A;
    localparam logic [7:0]       CH_LA    = 8'h61;
    localparam logic [7:0]       CH_LZ    = 8'h7A;
    localparam logic [7:0]       VAL_62   = 8'd62;
    localparam logic [7:0]       VAL_63   = 8'd63;
    localparam logic [7:0]       OFS_DIG  = CH_0 - 8'd52;
    localparam logic [7:0]       OFS_LOW  = CH_LA - 8'd26;

    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_PAD     = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // Up to three result beats produced by one input beat.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [1:0]                last_idx;
        logic                      has_byte;
        logic                      done;
        t_status                   status;
        logic [OUT_COUNT_W-1:0]    count;
    } t_bundle;

    function automatic logic [7:0] map_symbol(input logic [7:0] c);
        logic [7:0] r;
        if (c == CH_PAD) begin
            r = {1'b0, PAD_MARK};
        end else if (c == CH_PLUS) begin
            r = VAL_62;
        end else if (c == CH_SLASH) begin
            r = VAL_63;
        end else if (c >= CH_0 && c <= CH_9) begin
            r = c - OFS_DIG;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            r = c - CH_UA;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            r = c - OFS_LOW;
        end else begin
            r = BAD_MARK;
        end
        return r;
    endfunction

    // Pad widens to all ones.
    function automatic logic [7:0] wide_val(input logic [SYM_W-1:0] v);
        return (v == PAD_MARK) ? 8'hFF : {2'b00, v[5:0]};
    endfunction

    function automatic logic [7:0] shr_val(input logic [SYM_W-1:0] v, input logic [2:0] n);
        return (v == PAD_MARK) ? 8'hFF : ({2'b00, v[5:0]} >> n);
    endfunction

endpackage

/* hdl/b64d_in_if.sv */
// Input channel: one text character per beat.
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_text;

    modport source (output valid, output symbol, output end_of_text, input ready);
    modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

/* hdl/b64d_out_if.sv */
// Output channel: one decoded byte or end-of-text summary per beat.
interface b64d_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [23:0] byte_count;

    modport source (output valid, output data_byte, output byte_valid, output done_res,
                    output status, output byte_count, input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input done_res,
                    input status, input byte_count, output ready);
endinterface

/* hdl/base64_decoder_unit.sv */
// Base64 decoder top level: decode stage feeding a result serializer.
//
//  channel  | dir | beat payload
//  ---------+-----+-----------------------------------------------------------
//  i_in     | in  | symbol[7:0], end_of_text
//  o_out    | out | data_byte[7:0], byte_valid, done_res, status[1:0], byte_count[23:0]
//
// One character per cycle unless stalled; a character enters the decode stage the cycle
// after its beat and its bytes leave from the result register one per cycle after that.
// A full group gives up to three beats, so the serializer port sets the ceiling.
// Synchronous reset clears group fill, stop flag, total and both valid bits.
// A stall on o_out holds the result register and backs up through the input register.
module base64_decoder_unit
    import b64d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    b64d_in_if.sink    i_in,
    b64d_out_if.source o_out
);

    logic    bundle_free;
    logic    bundle_load;
    t_bundle bundle;

    b64d_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_symbol      (i_in.symbol),
        .i_end_of_text (i_in.end_of_text),
        .i_bundle_free (bundle_free),
        .o_bundle_load (bundle_load),
        .o_bundle      (bundle)
    );

    b64d_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (bundle_load),
        .i_bundle     (bundle),
        .o_free       (bundle_free),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_data_byte  (o_out.data_byte),
        .o_byte_valid (o_out.byte_valid),
        .o_done_res   (o_out.done_res),
        .o_status     (o_out.status),
        .o_byte_count (o_out.byte_count)
    );

endmodule

/* hdl/b64d_decode.sv */
// Input register, group state and single-pass decode of one character.
module b64d_decode
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_symbol,
    input  logic       i_end_of_text,
    input  logic       i_bundle_free,
    output logic       o_bundle_load,
    output t_bundle    o_bundle
);

    logic                   r_in_valid;
    logic [7:0]             r_symbol;
    logic                   r_eot;
    logic [SYM_W-1:0]       r_grp [GROUP_LEN-1];
    logic [1:0]             r_fill;
    logic                   r_stopped;
    t_status                r_reason;
    logic [COUNT_WIDTH-1:0] r_total;

    logic [7:0]             code;
    logic                   bad;
    logic                   take_sym;
    logic                   full;
    logic [SYM_W-1:0]       s3;
    logic [1:0]             n_bytes;
    logic                   stop_pad;
    logic                   n_stopped;
    t_status                n_reason;
    logic [1:0]             n_fill;
    logic [COUNT_WIDTH+1:0] sum;
    logic [COUNT_WIDTH-1:0] n_total;
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] tot_ext;
    logic                   emits;
    logic                   advance;

    assign code     = map_symbol(r_symbol);
    assign bad      = (code == BAD_MARK);
    assign take_sym = !r_stopped && !bad;
    assign full     = take_sym && (r_fill == 2'd3);
    assign s3       = code[SYM_W-1:0];

    always_comb begin
        n_bytes  = 2'd0;
        stop_pad = 1'b0;
        if (full) begin
            if (r_grp[2] == PAD_MARK) begin
                n_bytes  = 2'd1;
                stop_pad = 1'b1;
            end else if (s3 == PAD_MARK) begin
                n_bytes  = 2'd2;
                stop_pad = 1'b1;
            end else begin
                n_bytes = 2'd3;
            end
        end
    end

    always_comb begin
        n_stopped = r_stopped;
        n_reason  = r_reason;
        if (!r_stopped && bad) begin
            n_stopped = 1'b1;
            n_reason  = ST_INVALID;
        end else if (stop_pad) begin
            n_stopped = 1'b1;
            n_reason  = ST_PAD;
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (take_sym) begin
            n_fill = r_fill + 2'd1;
        end
    end

    // Saturating running total; drop to zero on an invalid character.
    always_comb begin
        sum = {2'b00, r_total} + (COUNT_WIDTH + 2)'(n_bytes);
        if (!r_stopped && bad) begin
            n_total = '0;
        end else if (sum > {2'b00, {COUNT_WIDTH{1'b1}}}) begin
            n_total = {COUNT_WIDTH{1'b1}};
        end else begin
            n_total = sum[COUNT_WIDTH-1:0];
        end
    end

    assign tot_ext = {{OUT_COUNT_W{1'b0}}, n_total};

    always_comb begin
        o_bundle.bytes[0] = (wide_val(r_grp[0]) << 2) | shr_val(r_grp[1], 3'd4);
        o_bundle.bytes[1] = (wide_val(r_grp[1]) << 4) | shr_val(r_grp[2], 3'd2);
        o_bundle.bytes[2] = (wide_val(r_grp[2]) << 6) | wide_val(s3);
        o_bundle.has_byte = (n_bytes != 2'd0);
        o_bundle.last_idx = (n_bytes == 2'd0) ? 2'd0 : n_bytes - 2'd1;
        o_bundle.done     = r_eot;
        o_bundle.status   = n_stopped ? n_reason : ST_NORMAL;
        o_bundle.count    = (n_stopped && n_reason == ST_INVALID) ? '0
                          : tot_ext[OUT_COUNT_W-1:0];
    end

    assign emits         = (n_bytes != 2'd0) || r_eot;
    assign advance       = r_in_valid && (!emits || i_bundle_free);
    assign o_bundle_load = advance && emits;
    assign o_ready       = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_symbol <= i_symbol;
            r_eot    <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && take_sym && !full) begin
            for (int i = 0; i < GROUP_LEN - 1; i++) begin
                if (r_fill == 2'(i)) begin
                    r_grp[i] <= code[SYM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= 2'd0;
            r_stopped <= 1'b0;
            r_reason  <= ST_NORMAL;
            r_total   <= '0;
        end else if (advance) begin
            if (r_eot) begin
                r_fill    <= 2'd0;
                r_stopped <= 1'b0;
                r_reason  <= ST_NORMAL;
                r_total   <= '0;
            end else begin
                r_fill    <= n_fill;
                r_stopped <= n_stopped;
                r_reason  <= n_reason;
                r_total   <= n_total;
            end
        end
    end

endmodule

/* hdl/b64d_serializer.sv */
// Result register: holds one bundle and sends its beats one per cycle while i_ready is high.
module b64d_serializer
    import b64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_bundle     i_bundle,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_data_byte,
    output logic        o_byte_valid,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic [23:0] o_byte_count
);

    logic       r_valid;
    t_bundle    r_bundle;
    logic [1:0] r_idx;
    logic       at_last;
    logic       last_out;

    assign at_last  = (r_idx == r_bundle.last_idx);
    assign last_out = r_valid && i_ready && at_last;
    assign o_free   = !r_valid || last_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (last_out) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

    always_comb begin
        o_data_byte = 8'd0;
        if (r_bundle.has_byte) begin
            case (r_idx)
                2'd0:    o_data_byte = r_bundle.bytes[0];
                2'd1:    o_data_byte = r_bundle.bytes[1];
                2'd2:    o_data_byte = r_bundle.bytes[2];
                default: o_data_byte = 8'd0;
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_byte_valid = r_bundle.has_byte;
    assign o_done_res   = r_bundle.done && at_last;
    assign o_status     = o_done_res ? r_bundle.status : ST_NORMAL;
    assign o_byte_count = o_done_res ? r_bundle.count : '0;

endmodule
